// ----- hw/rtl/dlrt_pkg.sv -----
package dlrt_pkg;

  // Largest payload one read may ask for; longer requests are clipped to it.
  localparam int MAX_PAYLOAD = 16;

  // Request frame length in bytes: command, count, address, length, checksum.
  localparam int TX_BYTES = 5;

  // Depth of the job queue between front and back, and of the result buffer.
  localparam int JQ_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  // Configuration register reset value and register index.
  localparam logic [15:0] TIMEOUT_RESET     = 16'd200;
  localparam logic        REG_TIMEOUT_TICKS = 1'b0;

  // Input item types.
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CSUM    = 2'd3;

  // Work handed from the front to the back.
  typedef enum logic {
    JOB_TX,
    JOB_REPLY
  } job_op_t;

  typedef struct packed {
    job_op_t                   op;
    logic [TX_BYTES-1:0][7:0]  bytes;
    logic [1:0]                status;
    logic [7:0]                count;
    logic [7:0]                to_total;
    logic [7:0]                cs_total;
  } job_t;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
    logic [7:0] to_total;
    logic [7:0] cs_total;
  } res_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TX,
    BK_STATUS,
    BK_PAYLOAD
  } bk_state_t;

endpackage

// ----- hw/rtl/dlrt_job_fifo.sv -----
module dlrt_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  dlrt_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output dlrt_pkg::job_t rd_job,
  output logic          empty
);

  localparam int PTR_W = (dlrt_pkg::JQ_DEPTH > 1) ? $clog2(dlrt_pkg::JQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(dlrt_pkg::JQ_DEPTH + 1);

  dlrt_pkg::job_t    mem [dlrt_pkg::JQ_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full   = (cnt_r == CNT_W'(dlrt_pkg::JQ_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rptr_r];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(dlrt_pkg::JQ_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(dlrt_pkg::JQ_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_job;
    end
  end

endmodule

// ----- hw/rtl/dlrt_front.sv -----
module dlrt_front #(
  parameter int MAX_PAYLOAD = dlrt_pkg::MAX_PAYLOAD,
  parameter int IDX_W       = $clog2(MAX_PAYLOAD + 3)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_req_type,
  input  logic [7:0]       in_command_code,
  input  logic [7:0]       in_send_count,
  input  logic [7:0]       in_address,
  input  logic [4:0]       in_read_length,
  input  logic [7:0]       in_rx_byte,
  input  logic [15:0]      timeout_ticks,
  output logic             jq_push,
  output dlrt_pkg::job_t   jq_job,
  input  logic             jq_full,
  input  logic             drain_done,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  localparam int STORE_DEPTH = MAX_PAYLOAD + 3;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [IDX_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      ticks_r, ticks_nxt;
  logic [7:0]       to_cnt_r, to_cnt_nxt;
  logic [7:0]       cs_cnt_r, cs_cnt_nxt;
  logic             drain_pend_r, drain_pend_nxt;
  logic [7:0]       store [STORE_DEPTH];
  logic [7:0]       rd_data_r;
  logic             store_we;
  logic             accept;
  logic [7:0]       len_ext;
  logic [7:0]       len_sat;
  logic [7:0]       req_crc;
  logic             last_byte;
  logic [7:0]       want;
  logic [15:0]      ticks_dec;

  // Hold off new words while the job queue is full or a payload is still
  // being read out of the reply buffer.
  assign full    = jq_full || drain_pend_r;
  assign accept  = push && !full;
  assign rd_data = rd_data_r;

  // Request length clipped to the payload limit, and the request checksum.
  assign len_ext   = {3'b000, in_read_length};
  assign len_sat   = (len_ext > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : len_ext;
  assign req_crc   = 8'hFF - (in_command_code + in_send_count + in_address + len_sat - 8'h01);

  // The reply is complete with its checksum byte, after header and payload.
  assign last_byte = (rcv_cnt_r == IDX_W'(exp_len_r) + IDX_W'(2));
  assign want      = 8'hFF - (sum_r - 8'h01);
  assign ticks_dec = (ticks_r != 16'd0) ? ticks_r - 16'd1 : 16'd0;

  // Classify the accepted word, update the exchange state and queue work.
  always_comb begin
    busy_nxt       = busy_r;
    exp_len_nxt    = exp_len_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    sum_nxt        = sum_r;
    ticks_nxt      = ticks_r;
    to_cnt_nxt     = to_cnt_r;
    cs_cnt_nxt     = cs_cnt_r;
    drain_pend_nxt = drain_pend_r;
    store_we       = 1'b0;
    jq_push        = 1'b0;
    jq_job         = '0;
    jq_job.op      = dlrt_pkg::JOB_REPLY;
    jq_job.status  = dlrt_pkg::ST_NONE;

    if (drain_done) begin
      drain_pend_nxt = 1'b0;
    end

    if (accept) begin
      case (in_req_type)
        dlrt_pkg::REQ_START: begin
          if (!busy_r) begin
            jq_push         = 1'b1;
            jq_job.op       = dlrt_pkg::JOB_TX;
            jq_job.bytes[0] = in_command_code;
            jq_job.bytes[1] = in_send_count;
            jq_job.bytes[2] = in_address;
            jq_job.bytes[3] = len_sat;
            jq_job.bytes[4] = req_crc;
            busy_nxt        = 1'b1;
            exp_len_nxt     = len_sat[LEN_W-1:0];
            rcv_cnt_nxt     = '0;
            sum_nxt         = 8'h00;
            ticks_nxt       = timeout_ticks;
          end
        end
        dlrt_pkg::REQ_BYTE: begin
          if (busy_r) begin
            store_we = 1'b1;
            if (!last_byte) begin
              sum_nxt     = sum_r + in_rx_byte;
              rcv_cnt_nxt = rcv_cnt_r + IDX_W'(1);
            end else begin
              busy_nxt = 1'b0;
              jq_push  = 1'b1;
              if (want == in_rx_byte) begin
                jq_job.status  = dlrt_pkg::ST_OK;
                jq_job.count   = 8'(exp_len_r);
                drain_pend_nxt = (exp_len_r != '0);
              end else begin
                jq_job.status = dlrt_pkg::ST_CSUM;
                cs_cnt_nxt    = cs_cnt_r + 8'd1;
              end
            end
          end
        end
        dlrt_pkg::REQ_TICK: begin
          if (busy_r) begin
            ticks_nxt = ticks_dec;
            if (ticks_dec == 16'd0) begin
              busy_nxt      = 1'b0;
              to_cnt_nxt    = to_cnt_r + 8'd1;
              jq_push       = 1'b1;
              jq_job.status = dlrt_pkg::ST_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end

    jq_job.to_total = to_cnt_nxt;
    jq_job.cs_total = cs_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      exp_len_r    <= '0;
      rcv_cnt_r    <= '0;
      sum_r        <= 8'h00;
      ticks_r      <= 16'd0;
      to_cnt_r     <= 8'd0;
      cs_cnt_r     <= 8'd0;
      drain_pend_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      exp_len_r    <= exp_len_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      sum_r        <= sum_nxt;
      ticks_r      <= ticks_nxt;
      to_cnt_r     <= to_cnt_nxt;
      cs_cnt_r     <= cs_cnt_nxt;
      drain_pend_r <= drain_pend_nxt;
    end
  end

  // Reply buffer: one write port for received words, one registered read
  // port for the back end.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[rcv_cnt_r] <= in_rx_byte;
    end
    rd_data_r <= store[rd_addr];
  end

endmodule

// ----- hw/rtl/dlrt_back.sv -----
module dlrt_back #(
  parameter int MAX_PAYLOAD = dlrt_pkg::MAX_PAYLOAD,
  parameter int IDX_W       = $clog2(MAX_PAYLOAD + 3)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             jq_empty,
  input  dlrt_pkg::job_t   jq_job,
  output logic             jq_pop,
  output logic [IDX_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic             drain_done,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [1:0]       out_status,
  output logic             out_last,
  output logic [7:0]       out_timeout_total,
  output logic [7:0]       out_checksum_fail_total
);

  localparam int TXI_W  = $clog2(dlrt_pkg::TX_BYTES);
  localparam int OPTR_W = (dlrt_pkg::OUT_DEPTH > 1) ? $clog2(dlrt_pkg::OUT_DEPTH) : 1;
  localparam int OCNT_W = $clog2(dlrt_pkg::OUT_DEPTH + 1);
  localparam int SUM_W  = OCNT_W + 1;

  dlrt_pkg::bk_state_t st_r, st_nxt;
  dlrt_pkg::job_t      job_r, job_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [7:0]          idx_plus2;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_mem_r, s1_mem_nxt;
  dlrt_pkg::res_t      s1_res_r, s1_res_nxt;
  dlrt_pkg::res_t      wr_res;
  dlrt_pkg::res_t      omem [dlrt_pkg::OUT_DEPTH];
  dlrt_pkg::res_t      head;
  logic [OPTR_W-1:0]   owptr_r, owptr_nxt;
  logic [OPTR_W-1:0]   orptr_r, orptr_nxt;
  logic [OCNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic                can_issue;
  logic                pay_last;
  logic                pop_ok;

  // Issue only when the result buffer has room for this word as well as
  // the one already in flight.
  assign can_issue = (SUM_W'(ocnt_r) + SUM_W'(s1_valid_r)) < SUM_W'(dlrt_pkg::OUT_DEPTH);
  assign idx_plus2 = idx_r + 8'd2;
  assign rd_addr   = idx_plus2[IDX_W-1:0];
  assign pay_last  = (idx_r == job_r.count - 8'd1);

  // Sequencer that expands a job into result words, one per cycle while the result buffer has room.
  always_comb begin
    st_nxt       = st_r;
    job_nxt      = job_r;
    idx_nxt      = idx_r;
    s1_valid_nxt = 1'b0;
    s1_mem_nxt   = 1'b0;
    s1_res_nxt   = s1_res_r;
    jq_pop       = 1'b0;
    drain_done   = 1'b0;

    case (st_r)
      dlrt_pkg::BK_IDLE: begin
        if (!jq_empty) begin
          jq_pop  = 1'b1;
          job_nxt = jq_job;
          idx_nxt = 8'd0;
          st_nxt  = (jq_job.op == dlrt_pkg::JOB_TX) ? dlrt_pkg::BK_TX : dlrt_pkg::BK_STATUS;
        end
      end
      dlrt_pkg::BK_TX: begin
        if (can_issue) begin
          s1_valid_nxt        = 1'b1;
          s1_res_nxt.kind     = dlrt_pkg::KIND_TX;
          s1_res_nxt.data     = job_r.bytes[idx_r[TXI_W-1:0]];
          s1_res_nxt.status   = dlrt_pkg::ST_NONE;
          s1_res_nxt.last     = (idx_r == 8'(dlrt_pkg::TX_BYTES - 1));
          s1_res_nxt.to_total = job_r.to_total;
          s1_res_nxt.cs_total = job_r.cs_total;
          idx_nxt             = idx_r + 8'd1;
          if (idx_r == 8'(dlrt_pkg::TX_BYTES - 1)) begin
            st_nxt = dlrt_pkg::BK_IDLE;
          end
        end
      end
      dlrt_pkg::BK_STATUS: begin
        if (can_issue) begin
          s1_valid_nxt        = 1'b1;
          s1_res_nxt.kind     = dlrt_pkg::KIND_STATUS;
          s1_res_nxt.data     = 8'h00;
          s1_res_nxt.status   = job_r.status;
          s1_res_nxt.last     = (job_r.count == 8'd0);
          s1_res_nxt.to_total = job_r.to_total;
          s1_res_nxt.cs_total = job_r.cs_total;
          idx_nxt             = 8'd0;
          st_nxt = (job_r.count == 8'd0) ? dlrt_pkg::BK_IDLE : dlrt_pkg::BK_PAYLOAD;
        end
      end
      dlrt_pkg::BK_PAYLOAD: begin
        if (can_issue) begin
          s1_valid_nxt        = 1'b1;
          s1_mem_nxt          = 1'b1;
          s1_res_nxt.kind     = dlrt_pkg::KIND_PAYLOAD;
          s1_res_nxt.data     = 8'h00;
          s1_res_nxt.status   = dlrt_pkg::ST_NONE;
          s1_res_nxt.last     = pay_last;
          s1_res_nxt.to_total = job_r.to_total;
          s1_res_nxt.cs_total = job_r.cs_total;
          idx_nxt             = idx_r + 8'd1;
          if (pay_last) begin
            drain_done = 1'b1;
            st_nxt     = dlrt_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        st_nxt = dlrt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= dlrt_pkg::BK_IDLE;
      idx_r      <= 8'd0;
      s1_valid_r <= 1'b0;
      s1_mem_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_mem_r   <= s1_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    s1_res_r <= s1_res_nxt;
  end

  // Payload words pick up their byte from the buffer read issued in the previous cycle.
  always_comb begin
    wr_res = s1_res_r;
    if (s1_mem_r) begin
      wr_res.data = rd_data;
    end
  end

  // Result buffer toward the consumer.
  assign empty  = (ocnt_r == '0);
  assign pop_ok = pop && !empty;
  assign head   = omem[orptr_r];

  assign out_kind                = head.kind;
  assign out_data_byte           = head.data;
  assign out_status              = head.status;
  assign out_last                = head.last;
  assign out_timeout_total       = head.to_total;
  assign out_checksum_fail_total = head.cs_total;

  always_comb begin
    owptr_nxt = owptr_r;
    orptr_nxt = orptr_r;
    ocnt_nxt  = ocnt_r;
    if (s1_valid_r) begin
      owptr_nxt = (owptr_r == OPTR_W'(dlrt_pkg::OUT_DEPTH - 1)) ? '0 : owptr_r + OPTR_W'(1);
    end
    if (pop_ok) begin
      orptr_nxt = (orptr_r == OPTR_W'(dlrt_pkg::OUT_DEPTH - 1)) ? '0 : orptr_r + OPTR_W'(1);
    end
    if (s1_valid_r && !pop_ok) begin
      ocnt_nxt = ocnt_r + OCNT_W'(1);
    end else if (pop_ok && !s1_valid_r) begin
      ocnt_nxt = ocnt_r - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      owptr_r <= owptr_nxt;
      orptr_r <= orptr_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      omem[owptr_r] <= wr_res;
    end
  end

`ifndef SYNTHESIS
  // A word in flight always finds room in the result buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (ocnt_r < OCNT_W'(dlrt_pkg::OUT_DEPTH)))
    else $error("result buffer overflow");

  // The final payload word ends the job.
  a_payload_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dlrt_pkg::BK_PAYLOAD && can_issue && pay_last) |=> (st_r == dlrt_pkg::BK_IDLE))
    else $error("payload sequence did not end");

  // A popped job starts either a request frame or a completion.
  a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |=> (st_r == dlrt_pkg::BK_TX || st_r == dlrt_pkg::BK_STATUS))
    else $error("popped job not started");

  // A buffer read is only tagged onto a payload word.
  a_mem_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_mem_r) |-> (s1_res_r.kind == dlrt_pkg::KIND_PAYLOAD))
    else $error("buffer read on a non-payload word");
`endif

endmodule

// ----- hw/rtl/diag_link_read_transaction.sv -----
// Master side of a single-wire diagnostic read exchange. The front end takes
// one input word per clock while it does not report full (start, received
// byte or millisecond tick), keeps the exchange state and reply buffer, and
// queues jobs; the back end pops a job and then turns it into result words
// at one word per clock while its four-entry result buffer has room. A start
// yields its five request bytes as result words, and a good reply of N
// payload bytes a status word and N payload words. While a good reply's
// payload is being read out of the buffer the input reports full, since the
// reply buffer has a single read port, until the back end issues the last
// payload word; this waits while it is still emitting the request frame or
// the output stalls. Sustained rate is set by the back end's sequencer.
// timeout_ticks lives at byte address 0 and resets to 200.
module diag_link_read_transaction #(
  parameter int MAX_PAYLOAD = dlrt_pkg::MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input word channel.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_command_code,
  input  logic [7:0]  in_send_count,
  input  logic [7:0]  in_address,
  input  logic [4:0]  in_read_length,
  input  logic [7:0]  in_rx_byte,
  // Result word channel.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [7:0]  out_timeout_total,
  output logic [7:0]  out_checksum_fail_total,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_PAYLOAD + 3);

  logic [15:0]      timeout_ticks_r, timeout_ticks_nxt;
  logic             cfg_wr;
  logic             jq_push;
  dlrt_pkg::job_t   jq_wr_job;
  logic             jq_full;
  logic             jq_pop;
  dlrt_pkg::job_t   jq_rd_job;
  logic             jq_empty;
  logic             drain_done;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == dlrt_pkg::REG_TIMEOUT_TICKS);
  assign prdata = (paddr[2] == dlrt_pkg::REG_TIMEOUT_TICKS) ? {16'h0000, timeout_ticks_r} : 32'h0;

  always_comb begin
    timeout_ticks_nxt = timeout_ticks_r;
    if (cfg_wr) begin
      timeout_ticks_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= dlrt_pkg::TIMEOUT_RESET;
    end else begin
      timeout_ticks_r <= timeout_ticks_nxt;
    end
  end

  // Front end: classifies words and tracks the exchange.
  dlrt_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_command_code (in_command_code),
    .in_send_count   (in_send_count),
    .in_address      (in_address),
    .in_read_length  (in_read_length),
    .in_rx_byte      (in_rx_byte),
    .timeout_ticks   (timeout_ticks_r),
    .jq_push         (jq_push),
    .jq_job          (jq_wr_job),
    .jq_full         (jq_full),
    .drain_done      (drain_done),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  // Job queue between the two halves.
  dlrt_job_fifo u_job_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (jq_push),
    .wr_job (jq_wr_job),
    .full   (jq_full),
    .rd_en  (jq_pop),
    .rd_job (jq_rd_job),
    .empty  (jq_empty)
  );

  // Back end: emits result words.
  dlrt_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .jq_empty                (jq_empty),
    .jq_job                  (jq_rd_job),
    .jq_pop                  (jq_pop),
    .rd_addr                 (rd_addr),
    .rd_data                 (rd_data),
    .drain_done              (drain_done),
    .empty                   (empty),
    .pop                     (pop),
    .out_kind                (out_kind),
    .out_data_byte           (out_data_byte),
    .out_status              (out_status),
    .out_last                (out_last),
    .out_timeout_total       (out_timeout_total),
    .out_checksum_fail_total (out_checksum_fail_total)
  );

endmodule
